[src/weekly_alarm_next_event_finder_macros.svh]
`ifndef WEEKLY_ALARM_NEXT_EVENT_FINDER_MACROS_SVH
`define WEEKLY_ALARM_NEXT_EVENT_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WANEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WANEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wanef_pkg.sv]
package wanef_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ENTRY_INDEX_W = 4;
    localparam int DAYS_W        = 7;
    localparam int HOUR_W        = 5;
    localparam int MIN_W         = 6;
    localparam int KEY_W         = HOUR_W + MIN_W;
    localparam int WEEKDAY_W     = 3;
    localparam int OFF_W         = 3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              enabled;
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

    // Reduce 0..13 modulo 7.
    function automatic logic [2:0] wrap7(input logic [3:0] v);
        logic [3:0] r;
        r = (v >= 4'd7) ? (v - 4'd7) : v;
        return r[2:0];
    endfunction

endpackage

[src/wanef_if.sv]
interface wanef_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [wanef_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic                                entry_enabled;
    logic [wanef_pkg::DAYS_W-1:0]        entry_days;
    logic [wanef_pkg::HOUR_W-1:0]        entry_hour;
    logic [wanef_pkg::MIN_W-1:0]         entry_minute;
    logic [wanef_pkg::WEEKDAY_W-1:0]     now_weekday;
    logic [wanef_pkg::HOUR_W-1:0]        now_hour;
    logic [wanef_pkg::MIN_W-1:0]         now_minute;

    modport source (
        output valid, req_type, entry_index, entry_enabled, entry_days, entry_hour,
               entry_minute, now_weekday, now_hour, now_minute,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, entry_enabled, entry_days, entry_hour,
               entry_minute, now_weekday, now_hour, now_minute,
        output ready
    );
endinterface

interface wanef_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [wanef_pkg::WEEKDAY_W-1:0]     alarm_weekday;
    logic [wanef_pkg::HOUR_W-1:0]        alarm_hour;
    logic [wanef_pkg::MIN_W-1:0]         alarm_minute;
    logic [wanef_pkg::ENTRY_INDEX_W-1:0] alarm_index;

    modport source (
        output valid, found, alarm_weekday, alarm_hour, alarm_minute, alarm_index,
        input  ready
    );

    modport sink (
        input  valid, found, alarm_weekday, alarm_hour, alarm_minute, alarm_index,
        output ready
    );
endinterface

[src/wanef_ctrl.sv]
module wanef_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_req_type,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output wanef_pkg::cmd_t cmd,
    input  wanef_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == wanef_pkg::REQ_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/wanef_dp.sv]
module wanef_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wanef_pkg::cmd_t                     cmd,
    output wanef_pkg::sts_t                     sts,
    input  logic [wanef_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  logic                                entry_enabled,
    input  logic [wanef_pkg::DAYS_W-1:0]        entry_days,
    input  logic [wanef_pkg::HOUR_W-1:0]        entry_hour,
    input  logic [wanef_pkg::MIN_W-1:0]         entry_minute,
    input  logic [wanef_pkg::WEEKDAY_W-1:0]     now_weekday,
    input  logic [wanef_pkg::HOUR_W-1:0]        now_hour,
    input  logic [wanef_pkg::MIN_W-1:0]         now_minute,
    output logic                                found,
    output logic [wanef_pkg::WEEKDAY_W-1:0]     alarm_weekday,
    output logic [wanef_pkg::HOUR_W-1:0]        alarm_hour,
    output logic [wanef_pkg::MIN_W-1:0]         alarm_minute,
    output logic [wanef_pkg::ENTRY_INDEX_W-1:0] alarm_index
);

    wanef_pkg::entry_t                   table_reg [wanef_pkg::TABLE_ENTRIES];
    wanef_pkg::entry_t                   cur;

    logic [wanef_pkg::IDX_W-1:0]         scan_idx_reg;
    logic [wanef_pkg::WEEKDAY_W-1:0]     today_reg;
    logic [wanef_pkg::KEY_W-1:0]         now_key_reg;

    logic                                best_found_reg;
    logic [wanef_pkg::OFF_W-1:0]         best_off_reg;
    logic [wanef_pkg::KEY_W-1:0]         best_key_reg;
    logic [wanef_pkg::IDX_W-1:0]         best_idx_reg;

    logic [wanef_pkg::DAYS_W-1:0]        rot;
    logic [wanef_pkg::KEY_W-1:0]         cand_key;
    logic [wanef_pkg::OFF_W-1:0]         later_off;
    logic                                later_hit;
    logic [wanef_pkg::OFF_W-1:0]         cand_off;
    logic                                cand_valid;
    logic                                better;
    logic                                wr_ok;
    logic [wanef_pkg::IDX_W-1:0]         wr_idx;
    logic [wanef_pkg::WEEKDAY_W-1:0]     res_day;

    logic                                found_reg;
    logic [wanef_pkg::WEEKDAY_W-1:0]     weekday_reg;
    logic [wanef_pkg::HOUR_W-1:0]        hour_reg;
    logic [wanef_pkg::MIN_W-1:0]         minute_reg;
    logic [wanef_pkg::ENTRY_INDEX_W-1:0] index_reg;

    assign wr_ok    = int'(entry_index) < wanef_pkg::TABLE_ENTRIES;
    assign wr_idx   = wanef_pkg::IDX_W'(entry_index);
    assign cur      = table_reg[scan_idx_reg];
    assign cand_key = {cur.hour, cur.minute};
    assign sts.last = (scan_idx_reg == wanef_pkg::IDX_W'(wanef_pkg::TABLE_ENTRIES - 1));

    // Day mask rotated so that bit 0 is today, bit d is today + d.
    always_comb
    begin
        for (int d = 0; d < wanef_pkg::DAYS_W; d++)
        begin
            rot[d] = cur.days[wanef_pkg::wrap7(4'(today_reg) - 4'd1 + 4'(d))];
        end
    end

    // First following day with a set bit; lowest offset wins.
    always_comb
    begin
        later_hit = 1'b0;
        later_off = '0;
        for (int d = wanef_pkg::DAYS_W - 1; d >= 1; d--)
        begin
            if (rot[d])
            begin
                later_hit = 1'b1;
                later_off = wanef_pkg::OFF_W'(d);
            end
        end
    end

    // Offset 7 stands for today again, a week out.
    always_comb
    begin
        cand_off   = '0;
        cand_valid = 1'b0;
        if (rot[0] && (cand_key > now_key_reg))
        begin
            cand_off   = '0;
            cand_valid = 1'b1;
        end
        else if (later_hit)
        begin
            cand_off   = later_off;
            cand_valid = 1'b1;
        end
        else if (rot[0])
        begin
            cand_off   = wanef_pkg::OFF_W'(wanef_pkg::DAYS_W);
            cand_valid = 1'b1;
        end
        cand_valid = cand_valid && cur.enabled && (today_reg != '0);
    end

    // strict compare keeps the lowest index on ties
    assign better = cand_valid &&
                    (!best_found_reg || ({cand_off, cand_key} < {best_off_reg, best_key_reg}));

    assign res_day = wanef_pkg::WEEKDAY_W'(wanef_pkg::wrap7(4'(today_reg) - 4'd1
                     + 4'(best_off_reg))) + wanef_pkg::WEEKDAY_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg      <= '{default: '0};
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && wr_ok)
            begin
                table_reg[wr_idx] <= '{enabled: entry_enabled, days: entry_days,
                                       hour: entry_hour, minute: entry_minute};
            end
            if (cmd.start)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                scan_idx_reg <= scan_idx_reg + wanef_pkg::IDX_W'(1);
                if (better)
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            today_reg   <= now_weekday;
            now_key_reg <= {now_hour, now_minute};
        end
        if (cmd.step && better)
        begin
            best_off_reg <= cand_off;
            best_key_reg <= cand_key;
            best_idx_reg <= scan_idx_reg;
        end
        if (cmd.load_out)
        begin
            found_reg <= best_found_reg;
            if (best_found_reg)
            begin
                weekday_reg <= res_day;
                hour_reg    <= best_key_reg[wanef_pkg::KEY_W-1:wanef_pkg::MIN_W];
                minute_reg  <= best_key_reg[wanef_pkg::MIN_W-1:0];
                index_reg   <= wanef_pkg::ENTRY_INDEX_W'(best_idx_reg);
            end
            else
            begin
                weekday_reg <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
                index_reg   <= '0;
            end
        end
    end

    assign found         = found_reg;
    assign alarm_weekday = weekday_reg;
    assign alarm_hour    = hour_reg;
    assign alarm_minute  = minute_reg;
    assign alarm_index   = index_reg;

endmodule

[src/weekly_alarm_next_event_finder.sv]
// Weekly alarm finder with a 16-entry table. A write beat stores one entry and
// returns nothing. A query beat returns one result beat. The current time is
// latched on the accepting edge itself. The scan then steps through the 16
// table entries, one per cycle, through a single shared compare unit that keeps
// the best match so far, and then loads the result into the output register.
// The next beat can be taken in the cycle the result appears, so a new query
// is only taken once the previous one has finished. req.ready is low during the
// scan. While a result waits in the output register, new beats are still taken,
// and a query only finishes once that register has drained.
`include "weekly_alarm_next_event_finder_macros.svh"

module weekly_alarm_next_event_finder (
    input  logic        clk,
    input  logic        rst_n,
    wanef_req_if.sink   req,
    wanef_rsp_if.source rsp
);

    wanef_pkg::cmd_t cmd;
    wanef_pkg::sts_t sts;

    wanef_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    wanef_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .entry_index   (req.entry_index),
        .entry_enabled (req.entry_enabled),
        .entry_days    (req.entry_days),
        .entry_hour    (req.entry_hour),
        .entry_minute  (req.entry_minute),
        .now_weekday   (req.now_weekday),
        .now_hour      (req.now_hour),
        .now_minute    (req.now_minute),
        .found         (rsp.found),
        .alarm_weekday (rsp.alarm_weekday),
        .alarm_hour    (rsp.alarm_hour),
        .alarm_minute  (rsp.alarm_minute),
        .alarm_index   (rsp.alarm_index)
    );

    `WANEF_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.found, rsp.alarm_weekday == '0 && rsp.alarm_hour == '0 && rsp.alarm_minute == '0 && rsp.alarm_index == '0, "miss result not all zero")
    `WANEF_ASSERT_NOW(a_hit_day, rsp.valid && rsp.found, rsp.alarm_weekday != '0, "hit with weekday zero")
    `WANEF_ASSERT_NEXT(a_query_busy, req.valid && req.ready && req.req_type == wanef_pkg::REQ_QUERY, !req.ready, "ready high right after query")
    `WANEF_ASSERT_NEXT(a_load_valid, cmd.load_out, rsp.valid, "result loaded but not valid")

endmodule

[tb/weekly_alarm_next_event_finder_test.sv]
typedef struct packed {
    logic                                req_type;
    logic [wanef_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic                                entry_enabled;
    logic [wanef_pkg::DAYS_W-1:0]        entry_days;
    logic [wanef_pkg::HOUR_W-1:0]        entry_hour;
    logic [wanef_pkg::MIN_W-1:0]         entry_minute;
    logic [wanef_pkg::WEEKDAY_W-1:0]     now_weekday;
    logic [wanef_pkg::HOUR_W-1:0]        now_hour;
    logic [wanef_pkg::MIN_W-1:0]         now_minute;
} alarm_request_t;

typedef struct packed {
    logic                                found;
    logic [wanef_pkg::WEEKDAY_W-1:0]     weekday;
    logic [wanef_pkg::HOUR_W-1:0]        hour;
    logic [wanef_pkg::MIN_W-1:0]         minute;
    logic [wanef_pkg::ENTRY_INDEX_W-1:0] index;
} next_alarm_t;

class next_alarm_checker;
    wanef_pkg::entry_t alarm_table[wanef_pkg::TABLE_ENTRIES];
    next_alarm_t       pending_alarms[$];
    int                writes_seen;
    int                lookups_seen;
    int                hits;
    int                misses;
    int                later_day_hits;
    int                mismatches;

    function new();
        foreach (alarm_table[i])
        begin
            alarm_table[i] = '0;
        end
    endfunction

    // Today strictly after now, then the next six days at any time, then
    // today again at any time. Lowest slot wins a tie.
    function next_alarm_t predict_next_alarm(logic [2:0] today, logic [4:0] hour,
                                             logic [5:0] minute);
        next_alarm_t  r;
        logic [10:0]  now_key;
        logic [10:0]  key;
        logic [10:0]  best_key;
        int           best;
        int           day;
        r = '0;
        now_key = {hour, minute};
        best_key = '0;
        if (today == 3'd0)
            return r;
        for (int d = 0; d <= 7; d++)
        begin
            day = ((int'(today) + 6 + d) % 7) + 1;
            best = -1;
            for (int i = 0; i < wanef_pkg::TABLE_ENTRIES; i++)
            begin
                key = {alarm_table[i].hour, alarm_table[i].minute};
                if (alarm_table[i].enabled && alarm_table[i].days[day-1]
                    && (d != 0 || key > now_key) && (best < 0 || key < best_key))
                begin
                    best = i;
                    best_key = key;
                end
            end
            if (best >= 0)
            begin
                r.found   = 1'b1;
                r.weekday = 3'(day);
                r.hour    = alarm_table[best].hour;
                r.minute  = alarm_table[best].minute;
                r.index   = 4'(best);
                return r;
            end
        end
        return r;
    endfunction

    function void note_request(alarm_request_t beat);
        next_alarm_t want;
        if (beat.req_type == wanef_pkg::REQ_WRITE)
        begin
            alarm_table[beat.entry_index] = {beat.entry_enabled, beat.entry_days,
                                             beat.entry_hour, beat.entry_minute};
            writes_seen++;
        end
        else
        begin
            want = predict_next_alarm(beat.now_weekday, beat.now_hour, beat.now_minute);
            pending_alarms.push_back(want);
            lookups_seen++;
            if (want.found)
                hits++;
            else
                misses++;
            if (want.found && want.weekday != beat.now_weekday)
                later_day_hits++;
        end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got,
                                realtime stamp);
        if (got !== want)
        begin
            $display("%0.1f ns: %s mismatch, expected %0d, actual %0d",
                     stamp, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(next_alarm_t got, realtime stamp);
        next_alarm_t want;
        if (pending_alarms.size() == 0)
        begin
            $display("%0.1f ns: result beat with no lookup outstanding, actual %h",
                     stamp, got);
            mismatches++;
            return;
        end
        want = pending_alarms.pop_front();
        compare_field("found", 8'(want.found), 8'(got.found), stamp);
        compare_field("alarm_weekday", 8'(want.weekday), 8'(got.weekday), stamp);
        compare_field("alarm_hour", 8'(want.hour), 8'(got.hour), stamp);
        compare_field("alarm_minute", 8'(want.minute), 8'(got.minute), stamp);
        compare_field("alarm_index", 8'(want.index), 8'(got.index), stamp);
    endfunction
endclass

module weekly_alarm_next_event_finder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQUEST_TARGET = 1500;
    localparam int IDLE_PCT       = 13;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;
    bit   no_gaps;
    bit   hold_request;
    bit   pressure_done;
    int   items_sent;

    wanef_req_if req_ch();
    wanef_rsp_if rsp_ch();

    next_alarm_checker alarm_sb = new();

    weekly_alarm_next_event_finder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic alarm_request_t make_write(int idx, bit en, int days, int hour,
                                                  int minute);
        alarm_request_t r;
        r = $bits(alarm_request_t)'({$urandom, $urandom});
        r.req_type      = wanef_pkg::REQ_WRITE;
        r.entry_index   = 4'(idx);
        r.entry_enabled = en;
        r.entry_days    = 7'(days);
        r.entry_hour    = 5'(hour);
        r.entry_minute  = 6'(minute);
        return r;
    endfunction

    function automatic alarm_request_t make_query(int wd, int hour, int minute);
        alarm_request_t r;
        r = $bits(alarm_request_t)'({$urandom, $urandom});
        r.req_type    = wanef_pkg::REQ_QUERY;
        r.now_weekday = 3'(wd);
        r.now_hour    = 5'(hour);
        r.now_minute  = 6'(minute);
        return r;
    endfunction

    function automatic int random_hour();
        if (chance(30))
            return $urandom_range(8, 6);
        return chance(10) ? $urandom_range(31) : $urandom_range(23);
    endfunction

    function automatic int random_minute();
        if (chance(30))
            return chance(50) ? 0 : 30;
        return chance(10) ? $urandom_range(63) : $urandom_range(59);
    endfunction

    function automatic alarm_request_t random_entry_write();
        int days;
        case ($urandom_range(9))
            5, 6, 7: days = $urandom_range(127);
            8:       days = 0;
            9:       days = 7'h7f;
            default: days = 1 << $urandom_range(6);
        endcase
        return make_write($urandom_range(15), chance(85), days, random_hour(),
                          random_minute());
    endfunction

    // Often lands exactly on, or one minute short of, a stored entry's time.
    function automatic alarm_request_t random_query();
        int wd;
        int slot;
        int hour;
        int minute;
        wd = chance(6) ? 0 : $urandom_range(7, 1);
        slot = $urandom_range(15);
        if (chance(40))
        begin
            hour   = int'(alarm_sb.alarm_table[slot].hour);
            minute = int'(alarm_sb.alarm_table[slot].minute);
            if (minute > 0 && chance(50))
                minute--;
        end
        else
        begin
            hour   = random_hour();
            minute = random_minute();
        end
        return make_query(wd, hour, minute);
    endfunction

    task automatic drive_request(alarm_request_t r);
        while (!no_gaps && chance(IDLE_PCT))
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        {req_ch.req_type, req_ch.entry_index, req_ch.entry_enabled, req_ch.entry_days,
         req_ch.entry_hour, req_ch.entry_minute, req_ch.now_weekday, req_ch.now_hour,
         req_ch.now_minute} = r;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        alarm_sb.note_request(r);
        items_sent++;
        @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ch.ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            rsp_ch.ready = no_gaps || !chance(IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            alarm_sb.check_result({rsp_ch.found, rsp_ch.alarm_weekday, rsp_ch.alarm_hour,
                                   rsp_ch.alarm_minute, rsp_ch.alarm_index}, $realtime);
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        {req_ch.req_type, req_ch.entry_index, req_ch.entry_enabled, req_ch.entry_days,
         req_ch.entry_hour, req_ch.entry_minute, req_ch.now_weekday, req_ch.now_hour,
         req_ch.now_minute} = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        drive_request(make_query(1, 12, 0));           // empty table
        drive_request(make_write(15, 1, 7'h7f, 23, 59));
        drive_request(make_query(7, 23, 59));          // 23:59 not later, rolls to Monday
        drive_request(make_query(0, 0, 0));            // weekday zero never matches
        drive_request(make_write(0, 1, 7'h00, 0, 0));  // no day bits
        drive_request(make_write(3, 0, 7'h7f, 0, 0));  // disabled
        drive_request(make_query(3, 0, 0));
        drive_request(make_write(1, 1, 7'h04, 31, 63));
        drive_request(make_write(2, 1, 7'h04, 31, 63)); // tie, lower slot wins
        drive_request(make_query(3, 23, 59));
        drive_request(make_query(7, 31, 63));
        drive_request(make_write(15, 0, 7'h7f, 23, 59));
        drive_request(make_write(1, 0, 7'h04, 31, 63));
        drive_request(make_write(2, 0, 7'h04, 31, 63));
        drive_request(make_write(5, 1, 7'h04, 8, 0));  // lone Wednesday entry
        drive_request(make_query(3, 9, 0));            // full-week wrap
        drive_request(make_query(3, 8, 0));            // equal time also wraps
        drive_request(make_query(3, 7, 59));
        drive_request(make_query(4, 0, 0));            // six days ahead
        drive_request(make_write(6, 1, 7'h40, 0, 0));
        drive_request(make_query(7, 0, 0));            // Sunday to Wednesday across week end
        drive_request(make_query(6, 23, 59));

        while (items_sent < REQUEST_TARGET)
        begin
            no_gaps = (items_sent >= 1000 && items_sent < 1300);
            if (!pressure_done && items_sent >= 600)
            begin
                // keep offering lookups while results back up
                hold_request = 1'b1;
                pressure_done = 1'b1;
                repeat (12) drive_request(random_query());
            end
            if (chance(40))
            begin
                for (int i = 0; i < wanef_pkg::TABLE_ENTRIES; i++)
                    drive_request(make_write(i, 0, $urandom, $urandom, $urandom));
            end
            n = $urandom_range(6, 1);
            repeat (n) drive_request(random_entry_write());
            n = $urandom_range(6, 2);
            repeat (n)
            begin
                if (chance(20))
                    drive_request(random_entry_write());
                drive_request(random_query());
            end
        end
        no_gaps = 1'b0;
        req_ch.valid = 1'b0;

        while (alarm_sb.pending_alarms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d table writes and %0d next-alarm lookups (%0d hits, %0d empty).",
                 alarm_sb.writes_seen, alarm_sb.lookups_seen, alarm_sb.hits,
                 alarm_sb.misses);
        $display("%0d hits fell on a later weekday; one %0d-cycle output stall backed up input.",
                 alarm_sb.later_day_hits, HOLD_CYCLES);
        if (alarm_sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
